### design/lsra_pkg.sv
// Shared types and constants for the linear scan register allocator.
`timescale 1ns / 1ps
package lsra_pkg;

  localparam int MAX_REGS  = 16;
  localparam int MAX_VARS  = 256;
  localparam int REG_W     = 4;
  localparam int VAR_W     = 8;
  localparam int IDX_W     = 16;
  localparam int RANK_W    = 10;
  localparam int CNT_W     = 5;
  localparam int SLOT_W    = 9;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_SPILL = 2'd1;
  localparam logic [1:0] KIND_EVICT = 2'd2;

  typedef struct packed {
    logic              min_vld;
    logic [REG_W-1:0]  min_idx;
    logic              max_vld;
    logic [REG_W-1:0]  max_idx;
  } pick_t;

endpackage

### design/linear_scan_register_allocator_unit.sv
// Top level of the linear scan register allocator.
`timescale 1ns / 1ps
// An interval holds the block from its acceptance through the expire check, the decision and
// the action states, with an extra expire check and a write-back for each expired active
// interval and a second output state for a transfer that returns two results; in_tready is
// high only while the block is idle. Each expiry is a read-modify-write of the per-variable
// register cache memory; the decision step reads the cache and slot memories into registers
// for the action step. A result that waits on out_tready holds the block while it waits.
module linear_scan_register_allocator_unit import lsra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // variable, interval_start, interval_end, end_rank
  input  logic        in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // owner, rank, location, cached, pool_empty
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXP  = 3'd1;
  localparam logic [2:0] ST_EXPW = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_ACT  = 3'd4;
  localparam logic [2:0] ST_OUT2 = 3'd5;

  localparam logic [1:0] OP_ASSIGN = 2'd0;
  localparam logic [1:0] OP_SPILL  = 2'd1;
  localparam logic [1:0] OP_XFER   = 2'd2;

  logic [2:0]              state_r;
  logic [1:0]              op_r;
  logic [REG_W-1:0]        sel_r;
  logic [4:0]              num_regs_r;
  logic [VAR_W-1:0]        var_r;
  logic [IDX_W-1:0]        start_r;
  logic [IDX_W-1:0]        end_r;
  logic [RANK_W-1:0]       rank_r;

  logic [MAX_REGS-1:0]             act_vld_r;
  logic [MAX_REGS-1:0][IDX_W-1:0]  act_end_r;
  logic [MAX_REGS-1:0][RANK_W-1:0] act_rank_r;
  logic [MAX_REGS-1:0][VAR_W-1:0]  act_owner_r;
  logic [MAX_REGS-1:0][REG_W-1:0]  act_reg_r;
  logic [CNT_W-1:0]                act_cnt_r;
  logic [MAX_REGS-1:0]             busy_r;
  logic [MAX_REGS-1:0]             rev_vld_r;
  logic [MAX_REGS-1:0][VAR_W-1:0]  rev_var_r;
  logic [MAX_VARS-1:0]             cache_vld_r;
  logic [MAX_VARS-1:0]             slot_vld_r;
  logic [SLOT_W-1:0]               slot_cnt_r;

  logic [REG_W-1:0]  cache_mem [MAX_VARS];
  logic [SLOT_W-1:0] slot_mem  [MAX_VARS];
  logic [REG_W-1:0]  cache_rd_r;
  logic [SLOT_W-1:0] slot_rd_r;

  logic              out_vld_r;
  logic [1:0]        out_kind_r;
  logic [VAR_W-1:0]  out_owner_r;
  logic [RANK_W-1:0] out_rank_r;
  logic [7:0]        out_loc_r;
  logic              out_cached_r;
  logic              out_empty_r;
  logic              out_last_r;
  logic [VAR_W-1:0]  pend_owner_r;
  logic [RANK_W-1:0] pend_rank_r;
  logic [7:0]        pend_loc_r;

  pick_t pick;

  lsra_pick u_pick (
    .vld  (act_vld_r),
    .rank (act_rank_r),
    .pick (pick)
  );

  logic [CNT_W-1:0]  nregs;
  logic              can_push;
  logic              push;
  logic              expire;
  logic              full;
  logic              xfer;
  logic              cache_re;
  logic [VAR_W-1:0]  cache_ra;
  logic              slot_re;
  logic [VAR_W-1:0]  slot_ra;
  logic              cw_en;
  logic [VAR_W-1:0]  cw_var;
  logic [REG_W-1:0]  cw_reg;
  logic              cache_ok;
  logic              free_ok;
  logic [REG_W-1:0]  free_reg;
  logic              ent_ok;
  logic [REG_W-1:0]  free_ent;
  logic [REG_W-1:0]  new_reg;
  logic [VAR_W-1:0]  slot_var;
  logic [SLOT_W-1:0] slot_val;
  logic              slot_new;

  assign nregs    = (num_regs_r > CNT_W'(MAX_REGS)) ? CNT_W'(MAX_REGS) : num_regs_r;
  assign can_push = !out_vld_r || out_tready;
  assign push     = ((state_r == ST_ACT) || (state_r == ST_OUT2)) && can_push;
  assign in_tready = (state_r == ST_IDLE);

  assign expire = pick.min_vld && (act_end_r[pick.min_idx] < start_r);
  assign full   = act_cnt_r >= nregs;
  assign xfer   = full && pick.max_vld && (act_end_r[pick.max_idx] > end_r);

  always_comb begin
    free_ok  = 1'b0;
    free_reg = '0;
    for (int i = MAX_REGS - 1; i >= 0; i--) begin
      if (!busy_r[i] && (CNT_W'(i) < nregs)) begin
        free_ok  = 1'b1;
        free_reg = REG_W'(i);
      end
    end
    ent_ok   = 1'b0;
    free_ent = '0;
    for (int i = MAX_REGS - 1; i >= 0; i--) begin
      if (!act_vld_r[i]) begin
        ent_ok   = 1'b1;
        free_ent = REG_W'(i);
      end
    end
  end

  assign cache_ok = cache_vld_r[var_r] && (CNT_W'(cache_rd_r) < nregs) && !busy_r[cache_rd_r];
  assign new_reg  = cache_ok ? cache_rd_r : free_reg;

  assign slot_var = (op_r == OP_XFER) ? act_owner_r[sel_r] : var_r;
  assign slot_new = !slot_vld_r[slot_var];
  assign slot_val = slot_new ? slot_cnt_r : slot_rd_r;

  always_comb begin
    cache_re = 1'b0;
    cache_ra = var_r;
    slot_re  = 1'b0;
    slot_ra  = var_r;
    cw_en    = 1'b0;
    cw_var   = var_r;
    cw_reg   = new_reg;
    case (state_r)
      ST_EXP: begin
        cache_re = expire;
        cache_ra = act_owner_r[pick.min_idx];
      end
      ST_EXPW: begin
        cw_en  = 1'b1;
        cw_var = act_owner_r[sel_r];
        cw_reg = act_reg_r[sel_r];
      end
      ST_DEC: begin
        cache_re = 1'b1;
        slot_re  = 1'b1;
        slot_ra  = xfer ? act_owner_r[pick.max_idx] : var_r;
      end
      ST_ACT: begin
        if (can_push) begin
          if (op_r == OP_XFER) begin
            cw_en  = 1'b1;
            cw_reg = act_reg_r[sel_r];
          end else if (op_r == OP_ASSIGN) begin
            cw_en = (cache_ok || free_ok) && ent_ok;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cache_re) cache_rd_r <= cache_mem[cache_ra];
    if (cw_en) cache_mem[cw_var] <= cw_reg;
  end

  always_ff @(posedge clk) begin
    if (slot_re) slot_rd_r <= slot_mem[slot_ra];
    if (state_r == ST_ACT && can_push && op_r != OP_ASSIGN && slot_new) begin
      slot_mem[slot_var] <= slot_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_regs_r  <= 5'd16;
      act_vld_r   <= '0;
      act_cnt_r   <= '0;
      busy_r      <= '0;
      rev_vld_r   <= '0;
      cache_vld_r <= '0;
      slot_vld_r  <= '0;
      slot_cnt_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) num_regs_r <= cfg_wdata;
      if (out_vld_r && out_tready && !push) out_vld_r <= 1'b0;

      if (cw_en) begin
        if (cache_vld_r[cw_var] && cache_rd_r != cw_reg) rev_vld_r[cache_rd_r] <= 1'b0;
        if (rev_vld_r[cw_reg] && rev_var_r[cw_reg] != cw_var) begin
          cache_vld_r[rev_var_r[cw_reg]] <= 1'b0;
        end
        cache_vld_r[cw_var] <= 1'b1;
        rev_vld_r[cw_reg]   <= 1'b1;
        rev_var_r[cw_reg]   <= cw_var;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            var_r   <= in_tdata[7:0];
            start_r <= in_tdata[23:8];
            end_r   <= in_tdata[39:24];
            rank_r  <= in_tdata[49:40];
            if (in_tuser) begin
              act_vld_r   <= '0;
              act_cnt_r   <= '0;
              busy_r      <= '0;
              rev_vld_r   <= '0;
              cache_vld_r <= '0;
              slot_vld_r  <= '0;
              slot_cnt_r  <= '0;
            end
            state_r <= ST_EXP;
          end
        end
        ST_EXP: begin
          sel_r   <= pick.min_idx;
          state_r <= expire ? ST_EXPW : ST_DEC;
        end
        ST_EXPW: begin
          act_vld_r[sel_r]          <= 1'b0;
          act_cnt_r                 <= act_cnt_r - CNT_W'(1);
          busy_r[act_reg_r[sel_r]]  <= 1'b0;
          state_r                   <= ST_EXP;
        end
        ST_DEC: begin
          sel_r   <= pick.max_idx;
          op_r    <= xfer ? OP_XFER : (full ? OP_SPILL : OP_ASSIGN);
          state_r <= ST_ACT;
        end
        ST_ACT: begin
          if (can_push) begin
            out_vld_r    <= 1'b1;
            out_owner_r  <= var_r;
            out_rank_r   <= rank_r;
            if (op_r != OP_ASSIGN && slot_new) begin
              slot_vld_r[slot_var] <= 1'b1;
              slot_cnt_r           <= slot_cnt_r + SLOT_W'(1);
            end
            case (op_r)
              OP_SPILL: begin
                out_kind_r   <= KIND_SPILL;
                out_loc_r    <= slot_val[7:0];
                out_cached_r <= 1'b0;
                out_empty_r  <= 1'b0;
                out_last_r   <= 1'b1;
                state_r      <= ST_IDLE;
              end
              OP_XFER: begin
                out_kind_r         <= KIND_REG;
                out_loc_r          <= {{(8-REG_W){1'b0}}, act_reg_r[sel_r]};
                out_cached_r       <= 1'b0;
                out_empty_r        <= 1'b0;
                out_last_r         <= 1'b0;
                pend_owner_r       <= act_owner_r[sel_r];
                pend_rank_r        <= act_rank_r[sel_r];
                pend_loc_r         <= slot_val[7:0];
                act_end_r[sel_r]   <= end_r;
                act_rank_r[sel_r]  <= rank_r;
                act_owner_r[sel_r] <= var_r;
                state_r            <= ST_OUT2;
              end
              default: begin
                out_kind_r <= KIND_REG;
                out_last_r <= 1'b1;
                state_r    <= ST_IDLE;
                if ((cache_ok || free_ok) && ent_ok) begin
                  out_loc_r             <= {{(8-REG_W){1'b0}}, new_reg};
                  out_cached_r          <= cache_ok;
                  out_empty_r           <= 1'b0;
                  busy_r[new_reg]       <= 1'b1;
                  act_vld_r[free_ent]   <= 1'b1;
                  act_end_r[free_ent]   <= end_r;
                  act_rank_r[free_ent]  <= rank_r;
                  act_owner_r[free_ent] <= var_r;
                  act_reg_r[free_ent]   <= new_reg;
                  act_cnt_r             <= act_cnt_r + CNT_W'(1);
                end else begin
                  out_loc_r    <= '0;
                  out_cached_r <= 1'b0;
                  out_empty_r  <= 1'b1;
                end
              end
            endcase
          end
        end
        ST_OUT2: begin
          if (can_push) begin
            out_vld_r    <= 1'b1;
            out_kind_r   <= KIND_EVICT;
            out_owner_r  <= pend_owner_r;
            out_rank_r   <= pend_rank_r;
            out_loc_r    <= pend_loc_r;
            out_cached_r <= 1'b0;
            out_empty_r  <= 1'b0;
            out_last_r   <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, out_empty_r, out_cached_r, out_loc_r, out_rank_r, out_owner_r};

endmodule

### design/lsra_pick.sv
// Comparator tree that finds the first and the last active interval in rank order.
`timescale 1ns / 1ps
module lsra_pick import lsra_pkg::*; (
  input  logic [MAX_REGS-1:0]            vld,
  input  logic [MAX_REGS-1:0][RANK_W-1:0] rank,
  output pick_t                          pick
);

  typedef struct packed {
    logic              v;
    logic [REG_W-1:0]  idx;
    logic [RANK_W-1:0] rank;
  } node_t;

  function automatic node_t take_min(node_t a, node_t b);
    node_t res;
    if (!a.v) res = b;
    else if (!b.v) res = a;
    else res = (b.rank < a.rank) ? b : a;
    return res;
  endfunction

  function automatic node_t take_max(node_t a, node_t b);
    node_t res;
    if (!a.v) res = b;
    else if (!b.v) res = a;
    else res = (a.rank > b.rank) ? a : b;
    return res;
  endfunction

  node_t leaf [MAX_REGS];
  node_t mn1 [8];
  node_t mn2 [4];
  node_t mn3 [2];
  node_t mx1 [8];
  node_t mx2 [4];
  node_t mx3 [2];
  node_t mn4;
  node_t mx4;

  always_comb begin
    for (int i = 0; i < MAX_REGS; i++) begin
      leaf[i].v    = vld[i];
      leaf[i].idx  = REG_W'(i);
      leaf[i].rank = rank[i];
    end
    for (int i = 0; i < 8; i++) begin
      mn1[i] = take_min(leaf[2*i], leaf[2*i+1]);
      mx1[i] = take_max(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      mn2[i] = take_min(mn1[2*i], mn1[2*i+1]);
      mx2[i] = take_max(mx1[2*i], mx1[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      mn3[i] = take_min(mn2[2*i], mn2[2*i+1]);
      mx3[i] = take_max(mx2[2*i], mx2[2*i+1]);
    end
    mn4 = take_min(mn3[0], mn3[1]);
    mx4 = take_max(mx3[0], mx3[1]);
    pick.min_vld = mn4.v;
    pick.min_idx = mn4.idx;
    pick.max_vld = mx4.v;
    pick.max_idx = mx4.idx;
  end

endmodule

### tb/sv/lsra_checker.sv
// Watches the allocator's channels, predicts each assignment and compares results.
`timescale 1ns / 1ps
module lsra_checker import lsra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]        kind;
    logic [VAR_W-1:0]  owner;
    logic [RANK_W-1:0] rank;
    logic [7:0]        location;
    logic              cached;
    logic              pool_empty;
    logic              last;
  } alloc_result_t;

  alloc_result_t placements[$];

  logic [4:0]        reg_limit;
  logic              act_vld [MAX_REGS];
  logic [IDX_W-1:0]  act_end [MAX_REGS];
  logic [RANK_W-1:0] act_rank[MAX_REGS];
  logic [VAR_W-1:0]  act_own [MAX_REGS];
  logic [REG_W-1:0]  act_reg [MAX_REGS];
  int                act_cnt;
  logic              busy    [MAX_REGS];
  logic              home_vld[MAX_VARS];
  logic [REG_W-1:0]  home_reg[MAX_VARS];
  logic              slot_vld[MAX_VARS];
  logic [SLOT_W-1:0] slot_num[MAX_VARS];
  int                slot_cnt;

  assign pending = placements.size();

  function automatic void wipe_alloc();
    for (int i = 0; i < MAX_REGS; i++) begin
      act_vld[i] = 0;
      busy[i] = 0;
    end
    for (int v = 0; v < MAX_VARS; v++) begin
      home_vld[v] = 0;
      slot_vld[v] = 0;
    end
    act_cnt = 0;
    slot_cnt = 0;
  endfunction

  function automatic bit earlier(int a, int b);
    if (act_rank[a] != act_rank[b]) return act_rank[a] < act_rank[b];
    return a < b;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(logic [VAR_W-1:0] v);
    if (!slot_vld[v]) begin
      slot_vld[v] = 1;
      slot_num[v] = slot_cnt[SLOT_W-1:0];
      slot_cnt++;
    end
    return slot_num[v];
  endfunction

  function automatic void bind_home(logic [VAR_W-1:0] v, logic [REG_W-1:0] r);
    for (int k = 0; k < MAX_VARS; k++)
      if (home_vld[k] && home_reg[k] == r) home_vld[k] = 0;
    home_vld[v] = 1;
    home_reg[v] = r;
  endfunction

  function automatic alloc_result_t mk(logic [1:0] kind, logic [VAR_W-1:0] own,
                                       logic [RANK_W-1:0] rk, logic [7:0] loc,
                                       logic c, logic e, logic l);
    alloc_result_t x;
    x.kind = kind; x.owner = own; x.rank = rk; x.location = loc;
    x.cached = c; x.pool_empty = e; x.last = l;
    return x;
  endfunction

  function automatic void predict_alloc(logic restart, logic [VAR_W-1:0] v,
                                        logic [IDX_W-1:0] st, logic [IDX_W-1:0] en,
                                        logic [RANK_W-1:0] rk);
    int sel, nregs, reg_pick, entry;
    logic [REG_W-1:0] r;
    logic [VAR_W-1:0] vown;
    logic [RANK_W-1:0] vrank;
    logic [SLOT_W-1:0] s;
    logic from_home;
    nregs = reg_limit > MAX_REGS ? MAX_REGS : reg_limit;
    if (restart) wipe_alloc();
    forever begin
      sel = -1;
      for (int i = 0; i < MAX_REGS; i++)
        if (act_vld[i] && (sel < 0 || earlier(i, sel))) sel = i;
      if (sel < 0 || act_end[sel] >= st) break;
      act_vld[sel] = 0;
      act_cnt--;
      busy[act_reg[sel]] = 0;
      home_vld[act_own[sel]] = 1;
      home_reg[act_own[sel]] = act_reg[sel];
    end
    if (act_cnt >= nregs) begin
      sel = -1;
      for (int i = 0; i < MAX_REGS; i++)
        if (act_vld[i] && (sel < 0 || earlier(sel, i))) sel = i;
      if (sel >= 0 && act_end[sel] > en) begin
        vown = act_own[sel];
        vrank = act_rank[sel];
        r = act_reg[sel];
        bind_home(v, r);
        s = slot_of(vown);
        act_end[sel] = en; act_rank[sel] = rk; act_own[sel] = v;
        placements.push_back(mk(KIND_REG, v, rk, 8'(r), 0, 0, 0));
        placements.push_back(mk(KIND_EVICT, vown, vrank, s[7:0], 0, 0, 1));
        return;
      end
      s = slot_of(v);
      placements.push_back(mk(KIND_SPILL, v, rk, s[7:0], 0, 0, 1));
      return;
    end
    reg_pick = MAX_REGS;
    from_home = 0;
    entry = -1;
    if (home_vld[v] && home_reg[v] < nregs && !busy[home_reg[v]]) begin
      reg_pick = home_reg[v];
      from_home = 1;
    end else begin
      for (int i = nregs - 1; i >= 0; i--)
        if (!busy[i]) reg_pick = i;
    end
    for (int i = MAX_REGS - 1; i >= 0; i--)
      if (!act_vld[i]) entry = i;
    if (reg_pick >= nregs || entry < 0) begin
      placements.push_back(mk(KIND_REG, v, rk, 8'd0, 0, 1, 1));
      return;
    end
    busy[reg_pick] = 1;
    bind_home(v, REG_W'(reg_pick));
    act_vld[entry] = 1; act_end[entry] = en; act_rank[entry] = rk;
    act_own[entry] = v; act_reg[entry] = REG_W'(reg_pick);
    act_cnt++;
    placements.push_back(mk(KIND_REG, v, rk, 8'(reg_pick), from_home, 0, 1));
  endfunction

  always @(posedge clk) begin
    alloc_result_t want, got;
    if (!rst_n) begin
      reg_limit <= 5'd16;
      wipe_alloc();
      placements.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        predict_alloc(in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[39:24],
                      in_tdata[49:40]);
      if (out_tvalid && out_tready) begin
        got = mk(out_tuser, out_tdata[7:0], out_tdata[17:8], out_tdata[25:18],
                 out_tdata[26], out_tdata[27], out_tlast);
        if (placements.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transaction %h", got);
        end else begin
          want = placements.pop_front();
          if (want != got) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected kind %0d owner %0d rank %0d loc %0d",
                       want.kind, want.owner, want.rank, want.location,
                       " c %0d e %0d l %0d,", want.cached, want.pool_empty, want.last,
                       " got kind %0d owner %0d rank %0d loc %0d",
                       got.kind, got.owner, got.rank, got.location,
                       " c %0d e %0d l %0d", got.cached, got.pool_empty, got.last);
          end
        end
      end
      if (cfg_we) reg_limit <= cfg_wdata;
    end
  end

endmodule

### tb/sv/linear_scan_register_allocator_unit_tb.sv
// Stimulus and verdict for the linear scan register allocator testbench.
`timescale 1ns / 1ps
module linear_scan_register_allocator_unit_tb;
  import lsra_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  logic [15:0] cursor;
  bit          draining;

  linear_scan_register_allocator_unit dut (.*);
  lsra_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("linear_scan_register_allocator_unit_tb: errors");
    $finish;
  end

  // Result side stalls at random, with calm stretches.
  initial begin
    int hold;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if (out_tvalid && out_tready) hold = draining ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // The valid stays high after a transaction so that a following one can go back to back.
  task automatic send(logic restart, logic [7:0] v, logic [15:0] st, logic [15:0] en,
                      logic [9:0] rk);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) in_tvalid <= 0;
    repeat (gap) @(posedge clk);
    in_tvalid <= 1;
    in_tuser <= restart;
    in_tdata <= {6'd0, rk, en, st, v};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic quiesce();
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_limit(logic [4:0] n);
    quiesce();
    cfg_we <= 1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // One interval of a well-formed stream: starts never fall, ends mostly nearby.
  task automatic interval(logic restart, int vars);
    logic [15:0] st, en;
    if (restart) cursor = 0;
    cursor = cursor + 16'($urandom_range(0, 4));
    st = cursor;
    en = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                       : st + 16'($urandom_range(0, 40));
    send(restart, 8'($urandom_range(0, vars - 1)), st, en, 10'(en >> 6));
  endtask

  initial begin
    int nlim;
    rst_n = 0; cfg_we = 0; cfg_wdata = 0;
    in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    draining = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(1, 8'd0, 16'd0, 16'd65535, 10'd1023);
    send(0, 8'd255, 16'd0, 16'd10, 10'd0);
    send(0, 8'd1, 16'd11, 16'd5, 10'd0);
    send(0, 8'd255, 16'd20, 16'd30, 10'd3);
    send(0, 8'hAA, 16'hFFFF, 16'hFFFF, 10'h2AA);
    send(0, 8'h55, 16'hFFFF, 16'h0000, 10'h155);
    set_limit(5'd1);
    send(1, 8'd3, 16'd0, 16'd100, 10'd9);
    send(0, 8'd4, 16'd1, 16'd50, 10'd5);
    send(0, 8'd5, 16'd2, 16'd200, 10'd20);
    send(0, 8'd4, 16'd300, 16'd400, 10'd30);
    set_limit(5'd0);
    send(1, 8'd7, 16'd0, 16'd4, 10'd1);
    send(0, 8'd8, 16'd0, 16'd4, 10'd1);
    set_limit(5'd31);
    for (int i = 0; i < 18; i++) send(i == 0, 8'(i), 16'd0, 16'(1000 - i), 10'(500 - i));
    set_limit(5'd2);
    send(0, 8'd9, 16'd2000, 16'd2001, 10'd0);
    set_limit(5'd16);
    draining = 1;
    quiesce();
    draining = 0;
    for (int ph = 0; ph < 6; ph++) begin
      nlim = (ph == 0) ? 16 : (ph == 1) ? 1 : (ph == 5) ? 31 : $urandom_range(1, 17);
      set_limit(5'(nlim));
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(0, 19) == 0)
          send(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom), 16'($urandom),
               10'($urandom));
        else
          interval(i % 60 == 0, (ph % 2) ? 24 : 256);
        if (i == 125 && ph == 2) quiesce();
      end
    end
    quiesce();
    if (fail_count == 0) begin
      $display("linear_scan_register_allocator_unit_tb: clean");
    end else begin
      $display("linear_scan_register_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule

### linear_scan_register_allocator_unit.f
design/lsra_pkg.sv
design/lsra_pick.sv
design/linear_scan_register_allocator_unit.sv
tb/sv/lsra_checker.sv
tb/sv/linear_scan_register_allocator_unit_tb.sv
